// ===== src/point_in_tile_polygon_test_top_defines.svh =====
// Assertion macros shared by the point-in-tile outline test RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef POINT_IN_TILE_POLYGON_TEST_TOP_DEFINES_SVH
`define POINT_IN_TILE_POLYGON_TEST_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define PITPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PITPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pitpt_pkg.sv =====
// Shared types, hitbox outline ROM and helper functions for the outline test.
// No dependencies; used by pitpt_reduce, pitpt_cell and the top level.
package pitpt_pkg;

    // Tile coordinates, 0..127
    typedef logic [6:0] coord_t;
    typedef logic [3:0] vcount_t;
    typedef logic signed [7:0] diff_t;
    typedef logic signed [15:0] wide_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } vertex_t;

    // Word handed from cell to cell
    typedef struct packed {
        coord_t  px;
        coord_t  py;
        logic [2:0] sel;
        vcount_t n;
        logic    parity;
        logic    decided;
        logic    verdict;
        coord_t  bottom;
        coord_t  right;
        coord_t  left;
    } item_t;

    // Vertex counts of the eight outlines
    localparam vcount_t OUTLINE_LEN [8] = '{4'd10, 4'd10, 4'd4, 4'd6,
                                           4'd4, 4'd4, 4'd4, 4'd4};

    function automatic vertex_t mkv(input coord_t x, input coord_t y);
        vertex_t v;
        v.x = x;
        v.y = y;
        return v;
    endfunction

    // Hitbox outline ROM, built from the tile size
    function automatic vertex_t rom_vertex(input logic [2:0] sel, input logic [3:0] idx,
                                           input coord_t t);
        logic [8:0] t3;
        coord_t q1;
        coord_t q2;
        coord_t q3;
        vertex_t v;
        t3 = 9'({t, 1'b0}) + 9'(t);
        q1 = t >> 2;
        q2 = t >> 1;
        q3 = coord_t'(t3 >> 2);
        v  = mkv('0, '0);
        case (sel)
            3'd0: begin // stairs up
                case (idx)
                    4'd0: v = mkv('0, t);
                    4'd1: v = mkv('0, q3);
                    4'd2: v = mkv(q1, q3);
                    4'd3: v = mkv(q1, q2);
                    4'd4: v = mkv(q2, q2);
                    4'd5: v = mkv(q2, q1);
                    4'd6: v = mkv(q3, q1);
                    4'd7: v = mkv(q3, '0);
                    4'd8: v = mkv(t, '0);
                    4'd9: v = mkv(t, t);
                    default: v = mkv('0, '0);
                endcase
            end
            3'd1: begin // stairs down
                case (idx)
                    4'd0: v = mkv('0, '0);
                    4'd1: v = mkv(q1, '0);
                    4'd2: v = mkv(q1, q1);
                    4'd3: v = mkv(q2, q1);
                    4'd4: v = mkv(q2, q2);
                    4'd5: v = mkv(q3, q2);
                    4'd6: v = mkv(q3, q3);
                    4'd7: v = mkv(t, q3);
                    4'd8: v = mkv(t, t);
                    4'd9: v = mkv('0, t);
                    default: v = mkv('0, '0);
                endcase
            end
            3'd2: begin // chest
                case (idx)
                    4'd0: v = mkv(7'd1, t);
                    4'd1: v = mkv(7'd1, t - 7'd21);
                    4'd2: v = mkv(t - 7'd1, t - 7'd21);
                    4'd3: v = mkv(t - 7'd1, t);
                    default: v = mkv('0, '0);
                endcase
            end
            3'd3: begin // stone
                case (idx)
                    4'd0: v = mkv(7'd2, t);
                    4'd1: v = mkv(7'd2, t - 7'd13);
                    4'd2: v = mkv(t - 7'd10, t - 7'd13);
                    4'd3: v = mkv(t - 7'd10, t - 7'd6);
                    4'd4: v = mkv(t - 7'd1, t - 7'd6);
                    4'd5: v = mkv(t - 7'd1, t);
                    default: v = mkv('0, '0);
                endcase
            end
            3'd4: begin // low box
                case (idx)
                    4'd0: v = mkv(7'd8, t);
                    4'd1: v = mkv(7'd8, t - 7'd12);
                    4'd2: v = mkv(t - 7'd7, t - 7'd12);
                    4'd3: v = mkv(t - 7'd7, t);
                    default: v = mkv('0, '0);
                endcase
            end
            3'd5: begin // low box, wide
                case (idx)
                    4'd0: v = mkv(7'd1, t);
                    4'd1: v = mkv(7'd1, t - 7'd14);
                    4'd2: v = mkv(t - 7'd1, t - 7'd14);
                    4'd3: v = mkv(t - 7'd1, t);
                    default: v = mkv('0, '0);
                endcase
            end
            3'd6: begin // barrel
                case (idx)
                    4'd0: v = mkv(7'd3, t);
                    4'd1: v = mkv(7'd3, '0);
                    4'd2: v = mkv(t - 7'd3, '0);
                    4'd3: v = mkv(t - 7'd3, t);
                    default: v = mkv('0, '0);
                endcase
            end
            default: begin // door
                case (idx)
                    4'd0: v = mkv(7'd2, t);
                    4'd1: v = mkv(7'd2, '0);
                    4'd2: v = mkv(t - 7'd26, '0);
                    4'd3: v = mkv(t - 7'd26, t);
                    default: v = mkv('0, '0);
                endcase
            end
        endcase
        return v;
    endfunction

    // Coordinate as a signed difference operand
    function automatic diff_t sdiff(input coord_t c);
        return diff_t'({1'b0, c});
    endfunction

    // num/den within [0,1], den nonzero
    function automatic logic frac_in_unit(input wide_t num, input wide_t den);
        if (den > 0)
            return (num >= 0) && (num <= den);
        return (num <= 0) && (num >= den);
    endfunction

endpackage

// ===== src/point_in_tile_polygon_test_top.sv =====
// An accepted point word goes through the remainder steps, then each edge cell in turn
// (the first takes the hand-off), then the output register.
// The front end takes a new word only once the shared 4-bit-per-cycle remainder unit is done
// with the last; the edge cells form a pipeline, so several words may be in flight.
// Reset (rst_n, asynchronous, active low) clears the sequencer, the cell valid bits and
// the output valid; the outline ROM is constant logic and needs no load.
module point_in_tile_polygon_test_top
    import pitpt_pkg::*;
#(
    parameter int TILE_SIZE    = 32,
    parameter int MAX_VERTICES = 10,
    parameter int NUM_OUTLINES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        point_valid,
    output logic        point_stall,
    input  logic [15:0] x_coord,
    input  logic [15:0] y_coord,
    input  logic [2:0]  polygon_select,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        inside_res,
    output logic [5:0]  bottom_edge_y,
    output logic [5:0]  right_edge_x,
    output logic [5:0]  left_edge_x
);

`include "point_in_tile_polygon_test_top_defines.svh"

    localparam coord_t TILE = coord_t'(TILE_SIZE);

    logic                    advance;
    logic                    hand_valid;
    item_t                   hand_item;
    logic [MAX_VERTICES-1:0] cell_valid;
    item_t                   cell_item [MAX_VERTICES];
    item_t                   last_item;
    logic                    last_inside;
    logic                    result_valid_reg, result_valid_next;
    logic                    inside_reg;
    logic [5:0]              bottom_reg;
    logic [5:0]              right_reg;
    logic [5:0]              left_reg;

    // Whole chain moves unless a finished word is waiting on a stalled output
    assign advance = !(result_valid_reg && result_stall);

    pitpt_reduce #(
        .TILE_SIZE   (TILE_SIZE),
        .MAX_VERTICES(MAX_VERTICES),
        .NUM_OUTLINES(NUM_OUTLINES)
    ) u_reduce (
        .clk           (clk),
        .rst_n         (rst_n),
        .point_valid   (point_valid),
        .point_stall   (point_stall),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .polygon_select(polygon_select),
        .take          (advance),
        .hand_valid    (hand_valid),
        .hand_item     (hand_item)
    );

    // Row of edge cells
    for (genvar k = 0; k < MAX_VERTICES; k++)
    begin : g_cell
        if (k == 0)
        begin : g_first
            pitpt_cell #(
                .TILE_SIZE(TILE_SIZE),
                .CELL_IDX (k)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .up_valid(hand_valid),
                .up_item (hand_item),
                .dn_valid(cell_valid[k]),
                .dn_item (cell_item[k])
            );
        end
        else
        begin : g_rest
            pitpt_cell #(
                .TILE_SIZE(TILE_SIZE),
                .CELL_IDX (k)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .up_valid(cell_valid[k-1]),
                .up_item (cell_item[k-1]),
                .dn_valid(cell_valid[k]),
                .dn_item (cell_item[k])
            );
        end
    end

    // Final verdict; an outside point keeps the default offsets
    assign last_item   = cell_item[MAX_VERTICES-1];
    assign last_inside = last_item.decided ? last_item.verdict : last_item.parity;

    assign result_valid_next = advance ? cell_valid[MAX_VERTICES-1] : result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            inside_reg <= last_inside;
            bottom_reg <= last_inside ? last_item.bottom[5:0] : 6'd0;
            right_reg  <= last_inside ? last_item.right[5:0]  : 6'd0;
            left_reg   <= last_inside ? last_item.left[5:0]   : TILE[5:0];
        end
    end

    assign result_valid  = result_valid_reg;
    assign inside_res    = inside_reg;
    assign bottom_edge_y = bottom_reg;
    assign right_edge_x  = right_reg;
    assign left_edge_x   = left_reg;

    // Checks
    `PITPT_ASSERT_NEXT(a_chain_frozen, !advance, $stable(cell_valid), "cell valid moved while output blocked")
    `PITPT_ASSERT_NEXT(a_handoff, hand_valid && advance, cell_valid[0], "word lost entering first cell")
    `PITPT_ASSERT_NEXT(a_drain, cell_valid[MAX_VERTICES-1] && advance, result_valid, "word lost at output")
    `PITPT_ASSERT_NOW(a_outside_defaults, result_valid && !inside_res, (bottom_edge_y == 6'd0) && (right_edge_x == 6'd0) && (left_edge_x == TILE[5:0]), "outside result with offsets set")

endmodule

// ===== src/pitpt_reduce.sv =====
// Front end: takes a point word, reduces x and y modulo the tile size
// (4 remainder bits per cycle) and looks up the outline length. Uses pitpt_pkg.
module pitpt_reduce
    import pitpt_pkg::*;
#(
    parameter int TILE_SIZE    = 32,
    parameter int MAX_VERTICES = 10,
    parameter int NUM_OUTLINES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        point_valid,
    output logic        point_stall,
    input  logic [15:0] x_coord,
    input  logic [15:0] y_coord,
    input  logic [2:0]  polygon_select,
    input  logic        take,
    output logic        hand_valid,
    output item_t       hand_item
);

    localparam logic [6:0] TILE7 = 7'(TILE_SIZE);
    localparam int         BITS_PER_STEP = 4;
    localparam int         STEPS = 16 / BITS_PER_STEP;

    typedef enum logic [2:0] {
        RED_IDLE = 3'b001,
        RED_RUN  = 3'b010,
        RED_HOLD = 3'b100
    } red_state_t;

    red_state_t  state_reg, state_next;
    logic [1:0]  step_reg, step_next;
    logic [15:0] xs_reg, xs_next;
    logic [15:0] ys_reg, ys_next;
    logic [5:0]  xr_reg, xr_next;
    logic [5:0]  yr_reg, yr_next;
    logic [2:0]  sel_reg, sel_next;
    logic        accept;
    logic [5:0]  xr_step;
    logic [5:0]  yr_step;
    vcount_t     len;
    logic        len_ok;

    // One restoring remainder step: shift a bit in, subtract the tile if it fits
    function automatic logic [5:0] rem_step(input logic [5:0] r, input logic b);
        logic [6:0] s;
        s = {r, b};
        if (s >= TILE7)
            s = s - TILE7;
        return s[5:0];
    endfunction

    // Four bits of both remainders per cycle, MSB first
    always_comb
    begin
        xr_step = xr_reg;
        yr_step = yr_reg;
        for (int k = 0; k < BITS_PER_STEP; k++)
        begin
            xr_step = rem_step(xr_step, xs_reg[15 - k]);
            yr_step = rem_step(yr_step, ys_reg[15 - k]);
        end
    end

    assign point_stall = !((state_reg == RED_IDLE) || ((state_reg == RED_HOLD) && take));
    assign accept      = point_valid && !point_stall;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        xs_next    = xs_reg;
        ys_next    = ys_reg;
        xr_next    = xr_reg;
        yr_next    = yr_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            RED_IDLE:
            begin
                if (accept)
                    state_next = RED_RUN;
            end
            RED_RUN:
            begin
                xs_next   = xs_reg << BITS_PER_STEP;
                ys_next   = ys_reg << BITS_PER_STEP;
                xr_next   = xr_step;
                yr_next   = yr_step;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'(STEPS - 1))
                    state_next = RED_HOLD;
            end
            RED_HOLD:
            begin
                if (accept)
                    state_next = RED_RUN;
                else if (take)
                    state_next = RED_IDLE;
            end
            default: state_next = RED_IDLE;
        endcase
        if (accept)
        begin
            xs_next   = x_coord;
            ys_next   = y_coord;
            xr_next   = '0;
            yr_next   = '0;
            sel_next  = polygon_select;
            step_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RED_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        xs_reg  <= xs_next;
        ys_reg  <= ys_next;
        xr_reg  <= xr_next;
        yr_reg  <= yr_next;
        sel_reg <= sel_next;
    end

    // Outline length; unused or oversize outlines have none
    assign len    = OUTLINE_LEN[sel_reg];
    assign len_ok = ({2'b00, sel_reg} < 5'(NUM_OUTLINES)) &&
                    ({1'b0, len} <= 5'(MAX_VERTICES));

    assign hand_valid = (state_reg == RED_HOLD);

    always_comb
    begin
        hand_item         = '0;
        hand_item.px      = {1'b0, xr_reg};
        hand_item.py      = {1'b0, yr_reg};
        hand_item.sel     = sel_reg;
        hand_item.n       = len_ok ? len : '0;
        hand_item.parity  = 1'b0;
        hand_item.decided = 1'b0;
        hand_item.verdict = 1'b0;
        hand_item.bottom  = '0;
        hand_item.right   = '0;
        hand_item.left    = coord_t'(TILE_SIZE);
    end

endmodule

// ===== src/pitpt_cell.sv =====
// One edge cell: tests outline edge CELL_IDX against the ray and updates
// the edge offsets, then registers the word for the next cell. Uses pitpt_pkg.
module pitpt_cell
    import pitpt_pkg::*;
#(
    parameter int TILE_SIZE = 32,
    parameter int CELL_IDX  = 0
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  advance,
    input  logic  up_valid,
    input  item_t up_item,
    output logic  dn_valid,
    output item_t dn_item
);

    localparam coord_t     TILE     = coord_t'(TILE_SIZE);
    localparam logic [4:0] IDX5     = 5'(CELL_IDX);
    localparam logic [4:0] NEXT5    = 5'(CELL_IDX + 1);

    logic       valid_reg, valid_next;
    item_t      item_reg, item_next;
    logic [3:0] j_idx;
    vertex_t    v3;
    vertex_t    v4;
    logic       edge_on;
    logic       chain_on;
    diff_t      dy;
    diff_t      dpx;
    wide_t      den;
    wide_t      na;
    wide_t      nb;
    logic       span_x;
    logic       span_y;

    // Edge endpoints; the last edge wraps to vertex 0
    assign j_idx    = (NEXT5 == {1'b0, up_item.n}) ? 4'd0 : NEXT5[3:0];
    assign v3       = rom_vertex(up_item.sel, IDX5[3:0], TILE);
    assign v4       = rom_vertex(up_item.sel, j_idx, TILE);
    assign edge_on  = (IDX5 < {1'b0, up_item.n}) && !up_item.decided;
    assign chain_on = (NEXT5 < {1'b0, up_item.n});

    // Intersection terms
    assign dy  = sdiff(v4.y) - sdiff(v3.y);
    assign dpx = sdiff(up_item.px) - sdiff(TILE);
    assign den = wide_t'(dy) * wide_t'(dpx);
    assign na  = wide_t'(sdiff(v4.x) - sdiff(TILE)) * wide_t'(dy)
               - wide_t'(sdiff(v4.x) - sdiff(v3.x)) * wide_t'(sdiff(v4.y) - sdiff(up_item.py));
    assign nb  = wide_t'(dpx) * wide_t'(sdiff(v4.y) - sdiff(up_item.py));

    assign span_x = ((v3.x <= up_item.px) && (v4.x >= up_item.px)) ||
                    ((v3.x >= up_item.px) && (v4.x <= up_item.px));
    assign span_y = ((v3.y <= up_item.py) && (v4.y >= up_item.py)) ||
                    ((v3.y >= up_item.py) && (v4.y <= up_item.py));

    always_comb
    begin
        item_next = up_item;
        // Ray crossing test; a level edge at the point's height may decide early
        if (edge_on)
        begin
            if (den == 0)
            begin
                if ((up_item.py == v3.y) && (up_item.px <= v4.x))
                begin
                    item_next.decided = 1'b1;
                    item_next.verdict = (up_item.px >= v3.x);
                end
            end
            else if (frac_in_unit(na, den) && frac_in_unit(nb, den))
            begin
                item_next.parity = !up_item.parity;
            end
        end
        // Edge offsets over the open vertex chain
        if (chain_on)
        begin
            if (span_x && (v3.y <= up_item.py))
                item_next.bottom = v3.y;
            if (span_y && (v3.x <= up_item.px))
                item_next.right = v3.x;
            if (span_y && (v3.x >= up_item.px))
                item_next.left = v3.x;
        end
    end

    assign valid_next = advance ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            item_reg <= item_next;
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

// ===== tb/sv/outline_hit_checker.sv =====
`timescale 1ns / 100ps
// Checker for the point-in-tile outline test: watches the point and result channels,
// predicts each result from its own copy of the hitbox outlines and compares fields.
// No dependencies; instantiated beside the block by the testbench top.
module outline_hit_checker #(
    parameter int TILE_SIZE    = 32,
    parameter int MAX_VERTICES = 10,
    parameter int NUM_OUTLINES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        point_valid,
    input  logic        point_stall,
    input  logic [15:0] x_coord,
    input  logic [15:0] y_coord,
    input  logic [2:0]  polygon_select,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic        inside_res,
    input  logic [5:0]  bottom_edge_y,
    input  logic [5:0]  right_edge_x,
    input  logic [5:0]  left_edge_x,
    output int          fail_count,
    output int          pending
);

    localparam int T  = TILE_SIZE;
    localparam int Q1 = T / 4;
    localparam int Q2 = 2 * T / 4;
    localparam int Q3 = 3 * T / 4;
    localparam int PRINT_LIMIT = 50;
    localparam int RING_DEPTH  = 64;

    // Hitbox outlines: stairs up, stairs down, chest, stone, low box, wide low box,
    // barrel, door. Unused slots are zero.
    localparam int CORNER_X [8][10] = '{
        '{0, 0, Q1, Q1, Q2, Q2, Q3, Q3, T, T},
        '{0, Q1, Q1, Q2, Q2, Q3, Q3, T, T, 0},
        '{1, 1, T - 1, T - 1, 0, 0, 0, 0, 0, 0},
        '{2, 2, T - 10, T - 10, T - 1, T - 1, 0, 0, 0, 0},
        '{8, 8, T - 7, T - 7, 0, 0, 0, 0, 0, 0},
        '{1, 1, T - 1, T - 1, 0, 0, 0, 0, 0, 0},
        '{3, 3, T - 3, T - 3, 0, 0, 0, 0, 0, 0},
        '{2, 2, T - 26, T - 26, 0, 0, 0, 0, 0, 0}
    };
    localparam int CORNER_Y [8][10] = '{
        '{T, Q3, Q3, Q2, Q2, Q1, Q1, 0, 0, T},
        '{0, 0, Q1, Q1, Q2, Q2, Q3, Q3, T, T},
        '{T, T - 21, T - 21, T, 0, 0, 0, 0, 0, 0},
        '{T, T - 13, T - 13, T - 6, T - 6, T, 0, 0, 0, 0},
        '{T, T - 12, T - 12, T, 0, 0, 0, 0, 0, 0},
        '{T, T - 14, T - 14, T, 0, 0, 0, 0, 0, 0},
        '{T, 0, 0, T, 0, 0, 0, 0, 0, 0},
        '{T, 0, 0, T, 0, 0, 0, 0, 0, 0}
    };
    localparam int CORNER_CNT [8] = '{10, 10, 4, 6, 4, 4, 4, 4};

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [2:0]  sel;
        logic        in_poly;
        logic [5:0]  bot_y;
        logic [5:0]  rgt_x;
        logic [5:0]  lft_x;
    } hit_t;

    // Predictions wait in a ring, oldest first
    hit_t expected_hits [RING_DEPTH];
    int   wr_count = 0;
    int   rd_count = 0;

    // num/den lies in [0,1], den nonzero
    function automatic bit within_unit(input int num, input int den);
        if (den > 0)
            return (num >= 0) && (num <= den);
        return (num <= 0) && (num >= den);
    endfunction

    // Ray cast to the tile's right edge, then the edge offsets when inside
    function automatic hit_t predict_hit(input logic [15:0] xw, input logic [15:0] yw,
                                         input logic [2:0] sel);
        hit_t h;
        int px, py, n, crossings, verdict, j;
        int x3, y3, x4, y4, den, na, nb;
        int bot, rgt, lft;
        bit hit, span_x, span_y;
        px = xw % T;
        py = yw % T;
        n = 0;
        if (sel < NUM_OUTLINES && CORNER_CNT[sel] <= MAX_VERTICES)
            n = CORNER_CNT[sel];
        crossings = 0;
        verdict = -1;
        for (int i = 0; i < n && verdict < 0; i++) begin
            j  = (i + 1 == n) ? 0 : i + 1;
            x3 = CORNER_X[sel][i];
            y3 = CORNER_Y[sel][i];
            x4 = CORNER_X[sel][j];
            y4 = CORNER_Y[sel][j];
            den = (y4 - y3) * (px - T);
            if (den == 0) begin
                // horizontal edge at the point's height settles it at once
                if (py == y3 && px <= x4)
                    verdict = (px >= x3) ? 1 : 0;
            end else begin
                na = (x4 - T) * (y4 - y3) - (x4 - x3) * (y4 - py);
                nb = (px - T) * (y4 - py);
                if (within_unit(na, den) && within_unit(nb, den))
                    crossings++;
            end
        end
        hit = (verdict >= 0) ? (verdict == 1) : crossings[0];

        // offsets from the open vertex chain, defaults when outside
        bot = 0;
        rgt = 0;
        lft = T;
        if (hit) begin
            for (int i = 0; i + 1 < n; i++) begin
                x3 = CORNER_X[sel][i];
                y3 = CORNER_Y[sel][i];
                x4 = CORNER_X[sel][i + 1];
                y4 = CORNER_Y[sel][i + 1];
                span_x = (x3 <= px && x4 >= px) || (x3 >= px && x4 <= px);
                span_y = (y3 <= py && y4 >= py) || (y3 >= py && y4 <= py);
                if (span_x && y3 <= py)
                    bot = y3;
                if (span_y && x3 <= px)
                    rgt = x3;
                if (span_y && x3 >= px)
                    lft = x3;
            end
        end
        h.x = xw;
        h.y = yw;
        h.sel = sel;
        h.in_poly = hit;
        h.bot_y = bot[5:0];
        h.rgt_x = rgt[5:0];
        h.lft_x = lft[5:0];
        return h;
    endfunction

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_LIMIT)
            $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
    end

    // Compare finished words against the oldest prediction, then log new points
    always @(posedge clk) begin : watch
        hit_t h;
        string tag;
        if (rst_n) begin
            if (result_valid && !result_stall) begin
                if (wr_count == rd_count) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    h = expected_hits[rd_count % RING_DEPTH];
                    rd_count++;
                    tag = $sformatf("point (%0d,%0d) outline %0d", h.x, h.y, h.sel);
                    if (inside_res !== h.in_poly)
                        report_mismatch($sformatf("%s inside_res got %0b expected %0b",
                                                  tag, inside_res, h.in_poly));
                    if (bottom_edge_y !== h.bot_y)
                        report_mismatch($sformatf("%s bottom_edge_y got %0d expected %0d",
                                                  tag, bottom_edge_y, h.bot_y));
                    if (right_edge_x !== h.rgt_x)
                        report_mismatch($sformatf("%s right_edge_x got %0d expected %0d",
                                                  tag, right_edge_x, h.rgt_x));
                    if (left_edge_x !== h.lft_x)
                        report_mismatch($sformatf("%s left_edge_x got %0d expected %0d",
                                                  tag, left_edge_x, h.lft_x));
                end
            end
            if (point_valid && !point_stall) begin
                if (wr_count - rd_count >= RING_DEPTH) begin
                    report_mismatch("more point words in flight than the checker holds");
                end else begin
                    expected_hits[wr_count % RING_DEPTH] =
                        predict_hit(x_coord, y_coord, polygon_select);
                    wr_count++;
                end
            end
            pending <= wr_count - rd_count;
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Top of the point-in-tile outline test bench: clock, reset, point stimulus and
// result back-pressure. Depends on the block's RTL and on outline_hit_checker.
module testbench;

    localparam int TILE_SIZE    = 32;
    localparam int N_RANDOM     = 1150;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 40;

    // Coordinates on or next to outline corners
    localparam int NOTABLE [21] = '{0, 1, 2, 3, 6, 7, 8, 11, 12, 13, 16, 18, 19, 20,
                                    22, 24, 25, 26, 29, 30, 31};

    logic        clk;
    logic        rst_n;
    logic        point_valid;
    logic        point_stall;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic [2:0]  polygon_select;
    logic        result_valid;
    logic        result_stall;
    logic        inside_res;
    logic [5:0]  bottom_edge_y;
    logic [5:0]  right_edge_x;
    logic [5:0]  left_edge_x;
    int          fail_count;
    int          pending;
    logic [3:0]  hold_req;
    int          idle_cycles = 0;

    point_in_tile_polygon_test_top #(
        .TILE_SIZE(TILE_SIZE)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .point_valid   (point_valid),
        .point_stall   (point_stall),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .polygon_select(polygon_select),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .inside_res    (inside_res),
        .bottom_edge_y (bottom_edge_y),
        .right_edge_x  (right_edge_x),
        .left_edge_x   (left_edge_x)
    );

    outline_hit_checker #(
        .TILE_SIZE(TILE_SIZE)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .point_valid   (point_valid),
        .point_stall   (point_stall),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .polygon_select(polygon_select),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .inside_res    (inside_res),
        .bottom_edge_y (bottom_edge_y),
        .right_edge_x  (right_edge_x),
        .left_edge_x   (left_edge_x),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: too long with no word moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (point_valid && !point_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result back-pressure: random runs, plus one long hold-off on request
    initial
    begin : receiver
        int   run;
        int   pick;
        logic level;
        logic [3:0] seen_hold;
        result_stall = 1'b0;
        run = 0;
        level = 1'b0;
        seen_hold = '0;
        forever
        begin
            @(posedge clk);
            if (hold_req != seen_hold)
            begin
                seen_hold = hold_req;
                level = 1'b1;
                run = HOLD_CYCLES;
            end
            else if (run == 0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    level = 1'b0;
                    run = $urandom_range(1, 6);
                end
                else if (pick < 85)
                begin
                    level = 1'b1;
                    run = $urandom_range(1, 3);
                end
                else if (pick < 93)
                begin
                    level = 1'b1;
                    run = $urandom_range(8, 30);
                end
                else
                begin
                    level = 1'b0;
                    run = $urandom_range(40, 120);
                end
            end
            run = run - 1;
            result_stall <= level;
        end
    end

    // Sender gap: mostly none, some short, a few long
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 0;
        if (pick < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Coordinate within the tile, leaning toward outline corners
    function automatic logic [4:0] local_coord();
        if ($urandom_range(0, 1) == 0)
            return 5'(NOTABLE[$urandom_range(0, 20)]);
        return 5'($urandom_range(0, TILE_SIZE - 1));
    endfunction

    // Offer one point word, hold it until taken, then maybe idle
    task automatic send_point(input logic [15:0] xw, input logic [15:0] yw,
                              input logic [2:0] sel, input bit no_gap);
        int gap;
        point_valid <= 1'b1;
        x_coord <= xw;
        y_coord <= yw;
        polygon_select <= sel;
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        gap = no_gap ? 0 : idle_gap();
        if (gap > 0)
        begin
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        logic [15:0] xw;
        logic [15:0] yw;
        logic [2:0]  sel;
        rst_n = 1'b0;
        point_valid = 1'b0;
        x_coord = '0;
        y_coord = '0;
        polygon_select = '0;
        hold_req = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every outline, horizontal edges at point height
        send_point(16'h0000, 16'h0000, 3'd0, 1'b0);
        send_point(16'hFFFF, 16'hFFFF, 3'd0, 1'b0);
        send_point(16'hFFFF, 16'h0000, 3'd1, 1'b0);
        send_point(16'h0000, 16'hFFFF, 3'd1, 1'b0);
        for (int s = 2; s < 8; s++)
            send_point(16'd16, 16'd30, 3'(s), 1'b0);
        send_point(16'd3, 16'd0, 3'd6, 1'b0);       // on start of top edge
        send_point(16'd2, 16'd0, 3'd6, 1'b0);       // left of top edge
        send_point(16'd29, 16'd0, 3'd6, 1'b0);      // on end of top edge
        send_point(16'd30, 16'd0, 3'd6, 1'b0);      // right of it: edge skipped
        send_point(16'h8006, 16'h4000, 3'd7, 1'b0); // door top edge, high bits set
        send_point(16'd7, 16'd0, 3'd7, 1'b0);
        send_point(16'd1, 16'd11, 3'd2, 1'b0);
        send_point(16'd31, 16'd11, 3'd2, 1'b0);
        send_point(16'd8, 16'd24, 3'd0, 1'b0);
        send_point(16'd24, 16'd8, 3'd1, 1'b0);
        send_point(16'd25, 16'd19, 3'd3, 1'b0);
        send_point(16'd30, 16'd26, 3'd3, 1'b0);
        send_point(16'd40, 16'd45, 3'd4, 1'b0);     // wraps into the next tile
        send_point(16'd20, 16'd31, 3'd5, 1'b0);

        // Random points, with one long result hold-off and one full drain
        for (int k = 0; k < N_RANDOM; k++)
        begin
            if (k == 300)
                hold_req <= hold_req + 4'd1;
            if (k == 650)
            begin
                point_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                xw = 16'($urandom);
                yw = 16'($urandom);
            end
            else
            begin
                xw = {11'($urandom), local_coord()};
                yw = {11'($urandom), local_coord()};
            end
            sel = 3'($urandom_range(0, 7));
            send_point(xw, yw, sel, (k >= 800 && k < 880));
        end
        point_valid <= 1'b0;

        // Drain, let the pipeline settle, then the verdict
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
